[rtl/tmps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared widths, defaults and types for the triangle min path sum core.
// ----------------------------------------------------------------------------
package tmps_pkg;

   // fixed field widths
   localparam int SUM_W = 24;
   localparam int CSR_W = 9;

   // parameter defaults
   localparam int MAX_ROWS_DEF   = 256;
   localparam int VALUE_BITS_DEF = 16;

   // per-entry position flags, decided when the transaction is accepted
   typedef struct packed {
      logic first_row;   // apex row: no parent
      logic col_zero;    // left edge: only the parent straight above
      logic at_end;      // right edge: only the upper-left parent
      logic last_row;    // bottom row: feeds the running minimum
      logic emit;        // last entry of the triangle
   } entry_ctl_type;

endpackage

[rtl/tmps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmps_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tmps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/triangle_min_path_sum_core.sv]
`timescale 1ns / 1ps
// Result: min_total is registered when the update stage completes the last entry.
// Throughput: one entry per cycle unless a held result stalls the update stage;
// the row store read is issued at acceptance and written back from the update
// stage, with a bypass for back-to-back accesses to the same entry.
// Reset: counters, partial minimum and left parent clear, row_count goes to 1;
// the row store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// triangle_min_path_sum_core
// Streams a number triangle row by row and returns its minimum top-to-bottom
// path sum. One row of best partial sums lives in a RAM, updated in place.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_core import tmps_pkg::*; #(
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_W-1:0]             csr_row_count,
   // entry stream
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_value,
   // result stream
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SUM_W-1:0]      rsp_min_total
);

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int CMP_W = ((IDX_W > CSR_W) ? IDX_W : CSR_W) + 1;
   localparam int EXT_W = (VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W;

   // configuration register
   logic [CSR_W-1:0] row_count_ff;

   // position counters
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;

   // update stage
   logic                         s1_valid_ff, s1_valid_in;
   entry_ctl_type                s1_ctl_ff, acc_ctl;
   logic [IDX_W-1:0]             s1_addr_ff;
   logic signed [VALUE_BITS-1:0] s1_value_ff;

   // same-entry bypass
   logic                    fwd_ff, fwd_in;
   logic signed [SUM_W-1:0] fwd_data_ff;

   // running state
   logic signed [SUM_W-1:0] left_ff, left_in;
   logic signed [SUM_W-1:0] run_min_ff, run_min_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_data_ff;

   logic                    acc;
   logic                    s1_go;
   logic [SUM_W-1:0]        ram_rd;
   logic signed [SUM_W-1:0] above;
   logic signed [SUM_W-1:0] parent;
   logic signed [EXT_W-1:0] value_ext;
   logic signed [SUM_W-1:0] fresh;

   // handshakes
   assign csr_ready = 1'b1;
   assign s1_go     = s1_valid_ff && (!s1_ctl_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign acc       = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         row_count_ff <= csr_row_count;
      end
   end

   // entry position flags at acceptance
   always_comb begin
      acc_ctl.first_row = (row_ff == '0);
      acc_ctl.col_zero  = (col_ff == '0);
      acc_ctl.at_end    = (col_ff == row_ff);
      acc_ctl.last_row  = ((CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(row_count_ff))
                          || (row_ff == IDX_W'(MAX_ROWS - 1));
      acc_ctl.emit      = acc_ctl.at_end && acc_ctl.last_row;
   end

   // counter advance
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (acc) begin
         if (acc_ctl.at_end) begin
            col_in = '0;
            row_in = acc_ctl.last_row ? '0 : IDX_W'(row_ff + 1'b1);
         end else begin
            col_in = IDX_W'(col_ff + 1'b1);
         end
      end
   end

   // bypass when the entry read now is the one written back this cycle
   assign fwd_in      = acc && s1_go && (s1_addr_ff == col_ff);
   assign s1_valid_in = acc || (s1_valid_ff && !s1_go);

   // row store: read at acceptance, write back from the update stage
   tmps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (fresh),
      .rd_en   (acc),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   // new partial sum
   always_comb begin
      above     = fwd_ff ? fwd_data_ff : $signed(ram_rd);
      value_ext = EXT_W'(s1_value_ff);
      if (s1_ctl_ff.first_row) begin
         parent = '0;
      end else if (s1_ctl_ff.col_zero) begin
         parent = above;
      end else if (s1_ctl_ff.at_end) begin
         parent = left_ff;
      end else begin
         parent = (left_ff < above) ? left_ff : above;
      end
      fresh = value_ext[SUM_W-1:0] + parent;
   end

   // left parent and bottom-row minimum
   always_comb begin
      left_in    = left_ff;
      run_min_in = run_min_ff;
      if (s1_go) begin
         if (s1_ctl_ff.emit) begin
            left_in = '0;
         end else if (!s1_ctl_ff.first_row && !s1_ctl_ff.at_end) begin
            left_in = above;
         end
         if (s1_ctl_ff.last_row && (s1_ctl_ff.col_zero || (fresh < run_min_ff))) begin
            run_min_in = fresh;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         left_ff      <= '0;
         run_min_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= acc ? fwd_in : fwd_ff;
         left_ff      <= left_in;
         run_min_ff   <= run_min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ctl_ff   <= acc_ctl;
         s1_addr_ff  <= col_ff;
         s1_value_ff <= req_value;
         fwd_data_ff <= fresh;
      end
      if (s1_go && s1_ctl_ff.emit) begin
         rsp_data_ff <= run_min_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_total = rsp_data_ff;

`ifndef ASSERT_OFF
   // column never runs past the row
   a_col_le_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= row_ff)
      else $error("column index beyond row index");

   // last entry of a triangle restarts the counters
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (acc && acc_ctl.emit) |=> (s1_valid_ff && row_ff == '0 && col_ff == '0))
      else $error("counters not cleared after last entry");

   // a stalled update blocks the input and keeps its entry
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> (!acc ##1 (s1_valid_ff && $stable(s1_addr_ff))))
      else $error("update stage lost a stalled entry");

   // a matching write-back at acceptance always sets the bypass
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      (acc && s1_valid_ff && s1_go && s1_addr_ff == col_ff) |=> fwd_ff)
      else $error("missing bypass on same-entry access");
`endif

endmodule

[test/triangle_min_path_sum_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_min_path_sum_core_tb
// Streams number triangles into the core and checks each minimum path sum
// against a predictor that keeps its own row of best sums. Covers one-row
// and zero-row settings, row count changes in the middle of a triangle,
// tall triangles at the value extremes, and random triangles with
// random gaps on the entry side and random stalls on the result side.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_core_tb;
   import tmps_pkg::*;

   localparam int MAX_ROWS    = MAX_ROWS_DEF;
   localparam int VALUE_BITS  = VALUE_BITS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int TALL_ROWS   = 24;
   localparam int unsigned TO_THE_END = 32'hFFFF_FFFF;

   logic clock;
   logic reset = 1'b1;

   logic                         csr_valid     = 1'b0;
   logic                         csr_ready;
   logic [CSR_W-1:0]             csr_row_count = '0;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic signed [VALUE_BITS-1:0] req_value     = '0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b1;
   logic signed [SUM_W-1:0]      rsp_min_total;

   triangle_min_path_sum_core #(
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_row_count (csr_row_count),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_min_total (rsp_min_total)
   );

   // predictor state
   logic signed [SUM_W-1:0] best_row [MAX_ROWS];
   int unsigned             cur_row;
   int unsigned             cur_col;
   logic signed [SUM_W-1:0] upper_left;
   logic signed [SUM_W-1:0] bottom_min;
   logic [CSR_W-1:0]        row_limit;
   logic signed [SUM_W-1:0] pending_totals [$];

   // bookkeeping
   int          mismatches   = 0;
   int unsigned entries_sent = 0;
   int          idle_cycles  = 0;
   logic [CSR_W-1:0] rows_now = 9'd1;
   bit          calm      = 1'b0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // zero rows acts as one, anything past the store depth as the full depth
   function automatic int unsigned eff_rows(input logic [CSR_W-1:0] n);
      if (n == 0)
         return 1;
      if (n > MAX_ROWS)
         return MAX_ROWS;
      return 32'(n);
   endfunction

   // fold one entry into the row of best sums; queue a total at triangle end
   function automatic void fold_entry(input logic signed [VALUE_BITS-1:0] v);
      int unsigned             r;
      int unsigned             c;
      logic signed [SUM_W-1:0] above;
      logic signed [SUM_W-1:0] pick;
      logic signed [SUM_W-1:0] fresh;
      bit                      bottom;
      r = (cur_row >= MAX_ROWS) ? MAX_ROWS - 1 : cur_row;
      c = (cur_col > r) ? r : cur_col;
      if (r == 0) begin
         fresh = SUM_W'(v);
      end else if (c == 0) begin
         above      = best_row[0];
         upper_left = above;
         fresh      = SUM_W'(v) + above;
      end else if (c == r) begin
         fresh = SUM_W'(v) + upper_left;
      end else begin
         above      = best_row[c];
         pick       = (upper_left < above) ? upper_left : above;
         upper_left = above;
         fresh      = SUM_W'(v) + pick;
      end
      best_row[c] = fresh;
      bottom = (r + 1 >= eff_rows(row_limit));
      if (bottom && (c == 0 || fresh < bottom_min))
         bottom_min = fresh;
      if (c == r) begin
         cur_col = 0;
         if (bottom) begin
            cur_row        = 0;
            upper_left     = '0;
            pending_totals = {pending_totals, bottom_min};
         end else begin
            cur_row = r + 1;
         end
      end else begin
         cur_col = c + 1;
         cur_row = r;
      end
   endfunction

   // predict on accepted entries, check accepted results, watch for hangs
   always @(posedge clock) begin
      logic signed [SUM_W-1:0] want;
      if (reset) begin
         cur_row     = 0;
         cur_col     = 0;
         upper_left  = '0;
         bottom_min  = '0;
         row_limit   = 9'd1;
         idle_cycles = 0;
         pending_totals.delete();
      end else begin
         if (csr_valid && csr_ready)
            row_limit = csr_row_count;
         if (req_valid && req_ready)
            fold_entry(req_value);
         if (rsp_valid && rsp_ready) begin
            if (pending_totals.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected min_total transaction, expected none, got %0d",
                        $time, rsp_min_total);
            end else begin
               want = pending_totals.pop_front();
               if (rsp_min_total !== want) begin
                  mismatches++;
                  $display("%0t: min_total mismatch, expected %0d, got %0d",
                           $time, want, rsp_min_total);
               end
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // result side back-pressure in random bursts, with quiet stretches
   initial begin
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0)
            rsp_quiet = !rsp_quiet;
         if (!calm && !rsp_quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic signed [VALUE_BITS-1:0] random_entry();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'h8000;
         2: return 16'sh0000;
         3: return 16'hFFFF;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // one entry transaction; valid stays high on return so entries can abut
   task automatic send_entry(input logic signed [VALUE_BITS-1:0] v);
      if (!calm) begin
         if ($urandom_range(0, 199) == 0)
            req_quiet = !req_quiet;
         if (!req_quiet && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entries_sent++;
   endtask

   // stop sending, wait for every queued total, then let the pipe drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_rows(input logic [CSR_W-1:0] n);
      settle();
      csr_valid     <= 1'b1;
      csr_row_count <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      rows_now = n;
   endtask

   // random entries from position (r, c) on; stops at triangle end or after cap
   task automatic feed_triangle(input int unsigned rows, inout int unsigned r,
                                inout int unsigned c, input int unsigned cap);
      int unsigned k;
      k = 0;
      while (k < cap) begin
         send_entry(random_entry());
         k++;
         if (c == r) begin
            c = 0;
            if (r + 1 >= rows) begin
               r = 0;
               break;
            end
            r++;
         end else begin
            c++;
         end
      end
   endtask

   function automatic logic [CSR_W-1:0] random_rows();
      case ($urandom_range(0, 19))
         0:       return 9'd0;
         1:       return CSR_W'($urandom_range(11, 40));
         default: return CSR_W'($urandom_range(1, 10));
      endcase
   endfunction

   // row_count left at one by reset: every entry is its own result
   task automatic test_single_row();
      send_entry(16'sh7FFF);
      send_entry(16'h8000);
      send_entry(16'sh0000);
      send_entry(16'hFFFF);
      // zero rows behaves as one row
      set_rows(9'd0);
      send_entry(16'sh1234);
      send_entry(16'h8001);
   endtask

   // hand-built triangles: edge parents, a tie, extreme entries
   task automatic test_small_triangles();
      set_rows(9'd2);
      send_entry(16'sd10);
      send_entry(16'sd3);
      send_entry(-16'sd4);
      set_rows(9'd3);
      send_entry(16'sd5);
      send_entry(-16'sd2);
      send_entry(-16'sd2);
      send_entry(16'sd1);
      send_entry(16'h8000);
      send_entry(16'sh7FFF);
   endtask

   // row_count rewritten in the middle of a triangle takes effect at once
   task automatic test_row_count_change();
      int unsigned r;
      int unsigned c;
      r = 0;
      c = 0;
      set_rows(9'd4);
      feed_triangle(4, r, c, 3);
      // shrink: the row in progress becomes the bottom row
      set_rows(9'd2);
      feed_triangle(2, r, c, TO_THE_END);
      set_rows(9'd2);
      feed_triangle(2, r, c, 1);
      // grow after the apex
      set_rows(9'd3);
      feed_triangle(3, r, c, TO_THE_END);
   endtask

   // tall triangles at both ends of the entry range
   task automatic test_value_extremes();
      set_rows(CSR_W'(TALL_ROWS));
      repeat (TALL_ROWS * (TALL_ROWS + 1) / 2) send_entry(16'sh7FFF);
      set_rows(CSR_W'(TALL_ROWS));
      repeat (TALL_ROWS * (TALL_ROWS + 1) / 2) send_entry(16'h8000);
   endtask

   task automatic test_random_triangles();
      int unsigned r;
      int unsigned c;
      int unsigned goal_entries;
      goal_entries = entries_sent + 700;
      set_rows(random_rows());
      while (entries_sent < goal_entries) begin
         if ($urandom_range(0, 1) == 0) begin
            // a stray setting that is overwritten before any entry
            if ($urandom_range(0, 3) == 0)
               set_rows(CSR_W'($urandom_range(0, 511)));
            set_rows(random_rows());
         end
         r = 0;
         c = 0;
         if ($urandom_range(0, 7) == 0) begin
            feed_triangle(eff_rows(rows_now), r, c, $urandom_range(1, 12));
            if (r != 0 || c != 0) begin
               set_rows(CSR_W'($urandom_range(1, 40)));
               feed_triangle(eff_rows(rows_now), r, c, TO_THE_END);
            end
         end else begin
            feed_triangle(eff_rows(rows_now), r, c, TO_THE_END);
         end
      end
   endtask

   // no gaps on the entry side and no stalls on the result side
   task automatic test_back_to_back();
      int unsigned r;
      int unsigned c;
      calm = 1'b1;
      r = 0;
      c = 0;
      set_rows(9'd1);
      repeat (30) send_entry(random_entry());
      set_rows(9'd5);
      repeat (6) feed_triangle(5, r, c, TO_THE_END);
      set_rows(9'd2);
      repeat (10) feed_triangle(2, r, c, TO_THE_END);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_single_row();
      test_small_triangles();
      test_row_count_change();
      test_value_extremes();
      test_random_triangles();
      test_back_to_back();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/tmps_pkg.sv
rtl/tmps_ram.sv
rtl/triangle_min_path_sum_core.sv
test/triangle_min_path_sum_core_tb.sv
